// ----- rtl/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, codes and defaults of the DMX to pixel segment mapper.
// ----------------------------------------------------------------------------
package dtp_pkg;

    // parameter defaults
    localparam int LED_MAX_DEF   = 1024;
    localparam int SLOTS_DEF     = 512;
    localparam int UNIVERSES_DEF = 4;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // divider width (led total over segment total)
    localparam int DIV_W = 12;

    // configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_PER_SEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIVERSE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_TOTAL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LED_TOTAL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_MODE   = 3'd5;

    // input function codes
    localparam logic [1:0] FUNC_FRAME    = 2'd0;
    localparam logic [1:0] FUNC_SLOT     = 2'd1;
    localparam logic [1:0] FUNC_FAILSAFE = 2'd2;

    // failsafe modes (anything else asks for a retransmit)
    localparam logic [1:0] FS_ZERO = 2'd0;
    localparam logic [1:0] FS_FULL = 2'd1;

    // result kinds
    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_RETX = 1'b1;

    // full intensity byte
    localparam logic [7:0] LEVEL_FULL = 8'hFF;

    // slot limits of channels per segment
    localparam logic [4:0] CPS_MIN = 5'd3;
    localparam logic [4:0] CPS_MAX = 5'd16;

    // register reset values
    localparam logic [9:0]  RST_START_ADDRESS = 10'd1;
    localparam logic [4:0]  RST_CPS           = 5'd3;
    localparam logic [2:0]  RST_UNIVERSES     = 3'd1;
    localparam logic [11:0] RST_SEGMENTS      = 12'd1;
    localparam logic [11:0] RST_PIXELS        = 12'd1;
    localparam logic [1:0]  RST_FAILSAFE      = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] universe;
        logic [8:0] slot;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  first_led;
        logic [10:0] led_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  brightness;
    } result_t;

    typedef struct packed {
        logic [9:0]  start_address;
        logic [4:0]  seg_channels;
        logic [2:0]  universe_count;
        logic [11:0] seg_total;
        logic [11:0] led_total;
        logic [1:0]  failsafe_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_FRAME,
        OP_SLOT,
        OP_FAILSAFE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [1:0] universe;
        logic [8:0] slot;
        logic [7:0] value;
    } cmd_t;

endpackage

// ----- rtl/dtp_front.sv -----
// ----------------------------------------------------------------------------
// dtp_front
// Accepts input words, drops those that cannot cause anything, and hands
// classified commands to the queue through a one-entry holding register.
// ----------------------------------------------------------------------------
module dtp_front
    import dtp_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int UNIVERSES = UNIVERSES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  push,
    input  item_t item,
    output logic  full,
    output logic  q_push,
    output cmd_t  q_data,
    input  logic  q_full
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    cmd_t       hold_reg;
    cmd_t       hold_next;
    logic       accept;
    logic       keep;
    logic       slot_ok;
    logic       univ_ok;
    logic       range_ok;
    logic       start_ok;
    logic [2:0] used_universes;
    cmd_t       cmd;

    // universe and slot window checks
    assign used_universes = (32'(cfg.universe_count) > UNIVERSES) ? 3'(UNIVERSES)
                                                                 : cfg.universe_count;
    assign univ_ok  = {1'b0, item.universe} < used_universes;
    assign range_ok = 32'(item.slot) < SLOTS;
    assign start_ok = (item.universe != 2'd0) ||
                      ((cfg.start_address != 10'd0) &&
                       ((10'(item.slot) + 10'd1) >= cfg.start_address));
    assign slot_ok  = univ_ok && range_ok && start_ok;

    // classify
    always_comb
    begin
        cmd.universe = item.universe;
        cmd.slot     = item.slot;
        cmd.value    = item.value;
        cmd.op       = OP_SLOT;
        keep         = 1'b0;
        case (item.func)
            FUNC_FRAME:
            begin
                cmd.op = OP_FRAME;
                keep   = 1'b1;
            end
            FUNC_SLOT:
            begin
                cmd.op = OP_SLOT;
                keep   = slot_ok;
            end
            FUNC_FAILSAFE:
            begin
                cmd.op = OP_FAILSAFE;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // handshake with the queue
    assign full   = hold_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = hold_valid_reg && !q_full;
    assign q_data = hold_reg;

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            hold_valid_next = 1'b1;
            hold_next       = cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ----- rtl/dtp_fifo.sv -----
// ----------------------------------------------------------------------------
// dtp_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dtp_fifo
    import dtp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dtp_div.sv -----
// ----------------------------------------------------------------------------
// dtp_div
// Restoring divider, one quotient bit per cycle, for the segment size.
// ----------------------------------------------------------------------------
module dtp_div
    import dtp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] dvs_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // one trial subtraction
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ~diff[DIV_W]};
            cnt_next = cnt_reg + 1'b1;
            if (32'(cnt_reg) == DIV_W - 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/dtp_back.sv -----
// ----------------------------------------------------------------------------
// dtp_back
// Carries out queued commands: frame setup, segment mapping and failsafe,
// and holds the result word until it is popped.
// ----------------------------------------------------------------------------
module dtp_back
    import dtp_pkg::*;
#(
    parameter int LED_MAX = LED_MAX_DEF,
    parameter int SLOTS   = SLOTS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_empty,
    input  cmd_t    q_data,
    output logic    q_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int LIM_W = $clog2(LED_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;
    logic [11:0]      seg_size_reg;
    logic [11:0]      seg_size_next;
    logic [LIM_W-1:0] led_limit_reg;
    logic [LIM_W-1:0] led_limit_next;
    logic [LIM_W-1:0] led_index_reg;
    logic [LIM_W-1:0] led_index_next;
    logic [11:0]      seg_index_reg;
    logic [11:0]      seg_index_next;
    logic [3:0]       pos_reg;
    logic [3:0]       pos_next;
    logic [1:0]       cur_univ_reg;
    logic [1:0]       cur_univ_next;
    logic             univ_active_reg;
    logic             univ_active_next;
    logic [7:0]       red_hold_reg;
    logic [7:0]       red_hold_next;
    logic [7:0]       green_hold_reg;
    logic [7:0]       green_hold_next;

    logic             out_pop;
    logic             out_free;
    logic             div_start;
    logic             div_done;
    logic [11:0]      div_quotient;
    logic             frame_clear;
    logic [LIM_W-1:0] limit_val;
    logic [4:0]       cps;
    logic             new_univ;
    logic [3:0]       pos_cur;
    logic [3:0]       pos_after;
    logic             seg_fits;
    logic             seg_go;
    logic [LIM_W-1:0] room;
    logic [LIM_W-1:0] fill_count;

    dtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.led_total),
        .divisor  (cfg.seg_total),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // output register handshake
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign out_pop  = pop && out_valid_reg;
    assign out_free = !out_valid_reg || out_pop;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty && out_free;

    // frame setup terms
    assign frame_clear = (cfg.seg_total == 12'd0) || (cfg.led_total == 12'd0);
    assign limit_val   = (32'(cfg.led_total) > LED_MAX) ? LIM_W'(LED_MAX)
                                                        : LIM_W'(cfg.led_total);

    // segment position tracking
    assign cps = (cfg.seg_channels < CPS_MIN) ? CPS_MIN :
                 (cfg.seg_channels > CPS_MAX) ? CPS_MAX :
                 cfg.seg_channels;
    assign new_univ  = !univ_active_reg || (cmd_reg.universe != cur_univ_reg);
    assign pos_cur   = new_univ ? 4'd0 : pos_reg;
    assign pos_after = (({1'b0, pos_cur} + 5'd1) >= cps) ? 4'd0 : pos_cur + 4'd1;

    // segment emission terms
    assign seg_fits = (cmd_reg.slot >= 9'd2) &&
                      ((32'(cmd_reg.slot) + 32'(cps)) <= (SLOTS + 2));
    assign seg_go   = seg_fits && (seg_index_reg < cfg.seg_total) &&
                      (led_index_reg < led_limit_reg);
    assign room       = led_limit_reg - led_index_reg;
    assign fill_count = (32'(seg_size_reg) < 32'(room)) ? LIM_W'(seg_size_reg) : room;

    // command sequencing
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        out_next         = out_reg;
        out_valid_next   = out_pop ? 1'b0 : out_valid_reg;
        seg_size_next    = seg_size_reg;
        led_limit_next   = led_limit_reg;
        led_index_next   = led_index_reg;
        seg_index_next   = seg_index_reg;
        pos_next         = pos_reg;
        cur_univ_next    = cur_univ_reg;
        univ_active_next = univ_active_reg;
        red_hold_next    = red_hold_reg;
        green_hold_next  = green_hold_reg;
        div_start        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next   = q_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (cmd_reg.op)
                    OP_FRAME:
                    begin
                        led_index_next   = '0;
                        seg_index_next   = '0;
                        pos_next         = '0;
                        cur_univ_next    = '0;
                        univ_active_next = 1'b0;
                        if (frame_clear)
                        begin
                            seg_size_next  = '0;
                            led_limit_next = '0;
                            out_valid_next = 1'b1;
                            out_next       = '{KIND_FILL, 10'd0, 11'(LED_MAX),
                                               8'd0, 8'd0, 8'd0, 8'd0};
                        end
                        else
                        begin
                            led_limit_next = limit_val;
                            div_start      = 1'b1;
                            state_next     = ST_DIV;
                        end
                    end
                    OP_SLOT:
                    begin
                        univ_active_next = 1'b1;
                        cur_univ_next    = cmd_reg.universe;
                        pos_next         = pos_after;
                        if (pos_cur == 4'd0)
                        begin
                            red_hold_next = cmd_reg.value;
                        end
                        else if (pos_cur == 4'd1)
                        begin
                            green_hold_next = cmd_reg.value;
                        end
                        else if ((pos_cur == 4'd2) && seg_go)
                        begin
                            seg_index_next = seg_index_reg + 12'd1;
                            if (fill_count != '0)
                            begin
                                led_index_next = led_index_reg + fill_count;
                                out_valid_next = 1'b1;
                                out_next       = '{KIND_FILL, 10'(led_index_reg),
                                                   11'(fill_count), red_hold_reg,
                                                   green_hold_reg, cmd_reg.value,
                                                   LEVEL_FULL};
                            end
                        end
                    end
                    OP_FAILSAFE:
                    begin
                        out_valid_next = 1'b1;
                        case (cfg.failsafe_mode)
                            FS_ZERO:
                            begin
                                out_next = '{KIND_FILL, 10'd0, 11'(LED_MAX),
                                             8'd0, 8'd0, 8'd0, 8'd0};
                            end
                            FS_FULL:
                            begin
                                out_next = '{KIND_FILL, 10'd0, 11'(LED_MAX), LEVEL_FULL,
                                             LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
                            end
                            default:
                            begin
                                out_next = '{KIND_RETX, 10'd0, 11'd0,
                                             8'd0, 8'd0, 8'd0, 8'd0};
                            end
                        endcase
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    seg_size_next = div_quotient;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, mapping registers and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            seg_size_reg    <= '0;
            led_limit_reg   <= '0;
            led_index_reg   <= '0;
            seg_index_reg   <= '0;
            pos_reg         <= '0;
            cur_univ_reg    <= '0;
            univ_active_reg <= 1'b0;
            red_hold_reg    <= '0;
            green_hold_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            seg_size_reg    <= seg_size_next;
            led_limit_reg   <= led_limit_next;
            led_index_reg   <= led_index_next;
            seg_index_reg   <= seg_index_next;
            pos_reg         <= pos_next;
            cur_univ_reg    <= cur_univ_next;
            univ_active_reg <= univ_active_next;
            red_hold_reg    <= red_hold_next;
            green_hold_reg  <= green_hold_next;
        end
    end

endmodule

// ----- rtl/dmx_to_pixel_segment_mapper.sv -----
// ----------------------------------------------------------------------------
// dmx_to_pixel_segment_mapper
// Maps DMX slot bytes onto runs of LED pixels as fill commands.
// ----------------------------------------------------------------------------
//
//  channel   handshake            word
//  -------   ------------------   ------------------------------------------
//  input     push / full          item   (func, universe, slot, value)
//  result    empty / pop          result (kind, first_led, led_count, rgb, bri)
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  A slot byte or failsafe event passes the back end as a queue pop plus
//  an execute step. A frame start with segments also waits for the
//  one-bit-per-cycle segment size divider.
//  Ignored words are dropped at the front and never reach the queue.
//  Reset clears control and mapping state at once; there is no clearing pass.
//  The front and a short queue keep accepting while a result waits in the
//  output register.
//
module dmx_to_pixel_segment_mapper
    import dtp_pkg::*;
#(
    parameter int LED_MAX   = LED_MAX_DEF,
    parameter int SLOTS     = SLOTS_DEF,
    parameter int UNIVERSES = UNIVERSES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  item_t                 item,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_push;
    cmd_t q_push_data;
    logic q_full;
    logic q_pop;
    cmd_t q_pop_data;
    logic q_empty;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_ADDRESS:    cfg_next.start_address  = cfg_data[9:0];
                REG_CHANNELS_PER_SEG: cfg_next.seg_channels   = cfg_data[4:0];
                REG_UNIVERSE_COUNT:   cfg_next.universe_count = cfg_data[2:0];
                REG_SEG_TOTAL:        cfg_next.seg_total      = cfg_data[11:0];
                REG_LED_TOTAL:        cfg_next.led_total      = cfg_data[11:0];
                REG_FAILSAFE_MODE:    cfg_next.failsafe_mode  = cfg_data[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{RST_START_ADDRESS, RST_CPS, RST_UNIVERSES,
                         RST_SEGMENTS, RST_PIXELS, RST_FAILSAFE};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept and classify
    dtp_front #(
        .SLOTS     (SLOTS),
        .UNIVERSES (UNIVERSES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_push (q_push),
        .q_data (q_push_data),
        .q_full (q_full)
    );

    // command queue
    dtp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // back end: execute and hold the result
    dtp_back #(
        .LED_MAX (LED_MAX),
        .SLOTS   (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ----- rtl/dtp_checker.sv -----
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks of the mapper's result words, bound to the top level.
// ----------------------------------------------------------------------------
module dtp_checker
    import dtp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // a waiting word holds until popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

    // retransmit words carry no range or color
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_RETX)) |->
        ((result.first_led == 10'd0) && (result.led_count == 11'd0) &&
         (result.red == 8'd0) && (result.green == 8'd0) && (result.blue == 8'd0) &&
         (result.brightness == 8'd0)))
        else $error("retransmit word with nonzero fields");

    // dark fills are whole-strip clears
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_FILL) && (result.brightness == 8'd0)) |->
        ((result.first_led == 10'd0) && (result.red == 8'd0) &&
         (result.green == 8'd0) && (result.blue == 8'd0)))
        else $error("dark fill not a whole-strip clear");

    // only segment fills start past the first led, always at full brightness
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_FILL) && (result.first_led != 10'd0)) |->
        ((result.brightness == LEVEL_FULL) && (result.led_count != 11'd0)))
        else $error("segment fill with wrong brightness or empty range");

endmodule

bind dmx_to_pixel_segment_mapper dtp_checker u_checker (.*);
